// ----- src/cfr_pkg.sv -----
// Shared types and constants for the checksum frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] LIMIT_RESET = 8'd250;
   localparam logic [7:0] MIN_LENGTH  = 8'd2;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_LEN     = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_CHECK   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_instruction;
      logic       end_of_frame;
      logic       frame_status;
   } result_type;

endpackage

// ----- src/cfr_if.sv -----
// Valid/ready channel interfaces for received bytes, results and the limit register.
`timescale 1ns / 1ps

interface cfr_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_instruction;
   logic       end_of_frame;
   logic       frame_status;

   modport source (output valid, output data_byte, output is_instruction,
                   output end_of_frame, output frame_status, input ready);
   modport sink   (input valid, input data_byte, input is_instruction,
                   input end_of_frame, input frame_status, output ready);
endinterface

interface cfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] length_limit;

   modport source (output valid, output length_limit, input ready);
   modport sink   (input valid, input length_limit, output ready);
endinterface

// ----- src/cfr_input_reg.sv -----
// Input register stage holding one received byte for the deframer.
`timescale 1ns / 1ps

module cfr_input_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_byte,
   output logic       req_ready,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_fire;

   // room when empty or when the held byte moves on this cycle
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_byte;
      end
   end

   assign in_valid = in_valid_ff;
   assign in_byte  = in_byte_ff;

endmodule

// ----- src/cfr_deframer.sv -----
// Frame state machine: start hunt, length check, payload pass-through, checksum compare.
`timescale 1ns / 1ps

module cfr_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               out_room,
   input  logic               csr_valid,
   input  logic [7:0]         csr_data,
   output logic               csr_ready,
   output logic               advance,
   output logic               res_valid,
   output cfr_pkg::result_type res
);

   cfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_ff, sum_in;
   logic       first_ff, first_in;
   logic [7:0] limit_ff;
   logic [7:0] sum_next;
   logic [7:0] left_next;
   logic       bad_length;

   assign csr_ready = 1'b1;
   assign advance   = in_valid && out_room;

   assign sum_next   = sum_ff + in_byte;
   assign left_next  = bytes_left_ff - 8'd1;
   assign bad_length = (in_byte < cfr_pkg::MIN_LENGTH) || (in_byte >= limit_ff);

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      first_in      = first_ff;
      res_valid     = 1'b0;
      res           = '0;
      unique case (phase_ff)
         cfr_pkg::PH_HUNT: begin
            if (in_byte == cfr_pkg::START_BYTE) begin
               phase_in = cfr_pkg::PH_LEN;
            end
         end
         cfr_pkg::PH_LEN: begin
            if (bad_length) begin
               phase_in = cfr_pkg::PH_HUNT;
            end else begin
               bytes_left_in = in_byte - 8'd1;
               sum_in        = in_byte;
               first_in      = 1'b1;
               phase_in      = cfr_pkg::PH_PAYLOAD;
            end
         end
         cfr_pkg::PH_PAYLOAD: begin
            res_valid          = 1'b1;
            res.data_byte      = in_byte;
            res.is_instruction = first_ff;
            sum_in             = sum_next;
            first_in           = 1'b0;
            bytes_left_in      = left_next;
            if (left_next == 8'd0) begin
               phase_in = cfr_pkg::PH_CHECK;
            end
         end
         cfr_pkg::PH_CHECK: begin
            res_valid        = 1'b1;
            res.end_of_frame = 1'b1;
            res.frame_status = (in_byte != ~sum_ff);
            phase_in         = cfr_pkg::PH_HUNT;
            bytes_left_in    = 8'd0;
            first_in         = 1'b0;
         end
         default: begin
            phase_in = cfr_pkg::PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cfr_pkg::PH_HUNT;
         bytes_left_ff <= 8'd0;
         sum_ff        <= 8'd0;
         first_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= cfr_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // a checksum byte always closes the frame
   a_check_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == cfr_pkg::PH_CHECK) |=> phase_ff == cfr_pkg::PH_HUNT)
      else $error("deframer did not return to hunt after checksum");

   a_payload_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == cfr_pkg::PH_PAYLOAD |-> bytes_left_ff != 8'd0)
      else $error("payload phase with no bytes left");

   a_first_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      first_ff |-> phase_ff == cfr_pkg::PH_PAYLOAD)
      else $error("instruction flag pending outside payload");

   a_no_hold_without_room: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !out_room) |=> $stable(phase_ff) && $stable(sum_ff))
      else $error("deframer state moved while stalled");

endmodule

// ----- src/cfr_result_reg.sv -----
// Result register presenting one deframed result to the output channel.
`timescale 1ns / 1ps

module cfr_result_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                res_valid,
   input  cfr_pkg::result_type res,
   output logic                out_room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cfr_pkg::result_type rsp_data
);

   logic                out_valid_ff;
   logic                out_valid_in;
   cfr_pkg::result_type out_data_ff;

   // free when empty or when the held result transfers this cycle
   assign out_room = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- src/checksum_frame_receiver_top.sv -----
// Top level of the checksum frame receiver.
`timescale 1ns / 1ps

// Deframes a byte stream of the form start byte 0xFF, length L, L-1 payload
// bytes, checksum. The block sustains one byte per cycle while rsp_chan takes
// its results; a byte is held in the input register and its result then in the
// result register, from which it is valid on rsp_chan, and back pressure on
// rsp_chan stalls req_chan only once both registers are full.
// Start and length bytes produce no result; each payload byte is passed on,
// the first flagged as the instruction, and the checksum byte yields an end
// marker whose frame_status is 1 when the byte differs from the inverted
// 8-bit sum of length and payload. Lengths below 2 or at or above the
// length_limit register (reset 250) drop the frame silently. csr_chan is
// always ready; write it only while no frame bytes are in flight.
module checksum_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   cfr_byte_if.sink     req_chan,
   cfr_result_if.source rsp_chan,
   cfr_csr_if.sink      csr_chan
);

   logic                advance;
   logic                out_room;
   logic                in_valid;
   logic [7:0]          in_byte;
   logic                res_valid;
   cfr_pkg::result_type res;
   cfr_pkg::result_type rsp_data;

   cfr_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.rx_byte),
      .req_ready (req_chan.ready),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_byte   (in_byte)
   );

   cfr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .out_room  (out_room),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.length_limit),
      .csr_ready (csr_chan.ready),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   cfr_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_room  (out_room),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.data_byte      = rsp_data.data_byte;
   assign rsp_chan.is_instruction = rsp_data.is_instruction;
   assign rsp_chan.end_of_frame   = rsp_data.end_of_frame;
   assign rsp_chan.frame_status   = rsp_data.frame_status;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the checksum frame receiver: byte stream in, deframed results out.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES = 8;

   // Tracks the deframer state and the results it should produce.
   class deframe_tracker;
      logic [7:0] limit;
      cfr_pkg::phase_type  phase;
      logic [7:0] bytes_left;
      logic [7:0] running_sum;
      logic       first_pending;
      cfr_pkg::result_type expected_results[$];
      int unsigned mismatches;

      function new();
         limit = cfr_pkg::LIMIT_RESET;
         phase = cfr_pkg::PH_HUNT;
         bytes_left = '0;
         running_sum = '0;
         first_pending = 1'b0;
         mismatches = 0;
      endfunction

      function void take_byte(logic [7:0] b);
         cfr_pkg::result_type r;
         logic [7:0] want;
         case (phase)
            cfr_pkg::PH_HUNT: begin
               if (b == cfr_pkg::START_BYTE) phase = cfr_pkg::PH_LEN;
            end
            cfr_pkg::PH_LEN: begin
               // drop bad headers; the length byte never counts as a new start
               if (b < cfr_pkg::MIN_LENGTH || b >= limit) begin
                  phase = cfr_pkg::PH_HUNT;
               end else begin
                  bytes_left = b - 8'd1;
                  running_sum = b;
                  first_pending = 1'b1;
                  phase = cfr_pkg::PH_PAYLOAD;
               end
            end
            cfr_pkg::PH_PAYLOAD: begin
               r.data_byte = b;
               r.is_instruction = first_pending;
               r.end_of_frame = 1'b0;
               r.frame_status = 1'b0;
               expected_results.push_back(r);
               running_sum = running_sum + b;
               first_pending = 1'b0;
               bytes_left = bytes_left - 8'd1;
               if (bytes_left == 8'd0) phase = cfr_pkg::PH_CHECK;
            end
            default: begin
               want = ~running_sum;
               r.data_byte = 8'h00;
               r.is_instruction = 1'b0;
               r.end_of_frame = 1'b1;
               r.frame_status = (b == want) ? 1'b0 : 1'b1;
               expected_results.push_back(r);
               phase = cfr_pkg::PH_HUNT;
               bytes_left = '0;
               first_pending = 1'b0;
            end
         endcase
      endfunction

      function void match_result(cfr_pkg::result_type got);
         cfr_pkg::result_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: data_byte %0h eof %0b", got.data_byte,
                   got.end_of_frame);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", want.data_byte, got.data_byte);
            mismatches++;
         end
         if (got.is_instruction !== want.is_instruction) begin
            $error("is_instruction: expected %0b, actual %0b", want.is_instruction,
                   got.is_instruction);
            mismatches++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, actual %0b", want.end_of_frame,
                   got.end_of_frame);
            mismatches++;
         end
         if (got.frame_status !== want.frame_status) begin
            $error("frame_status: expected %0b, actual %0b", want.frame_status,
                   got.frame_status);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cfr_byte_if   req_if ();
   cfr_result_if rsp_if ();
   cfr_csr_if    csr_if ();

   checksum_frame_receiver_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   deframe_tracker tracker = new();

   bit          gaps_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned stall_left = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   cfr_pkg::result_type rsp_seen;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.length_limit = cfr_pkg::LIMIT_RESET;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL checksum_frame_receiver_top");
         $finish;
      end
   end

   // Result side: check each transfer, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen = '{rsp_if.data_byte, rsp_if.is_instruction, rsp_if.end_of_frame,
                         rsp_if.frame_status};
            tracker.match_result(rsp_seen);
         end
         if (hold_request) begin
            stall_left = HOLD_CYCLES;
            hold_request <= 1'b0;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic offer_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      tracker.take_byte(b);
   endtask

   // Send start, length, payload and checksum; corrupt flips the checksum.
   task automatic send_frame(input logic [7:0] len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] pb;
      logic [7:0] ck;
      sum = len;
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(len);
      for (int i = 1; i < len; i++) begin
         case ($urandom_range(0, 15))
            0, 1:    pb = 8'hFF;
            2:       pb = 8'h00;
            default: pb = 8'($urandom_range(0, 255));
         endcase
         sum = sum + pb;
         offer_byte(pb);
      end
      ck = ~sum;
      if (corrupt) ck = ck ^ 8'($urandom_range(1, 255));
      offer_byte(ck);
   endtask

   task automatic send_random_frame();
      logic [7:0] hi;
      logic [7:0] len;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      hi = (tracker.limit > 8'd2) ? tracker.limit - 8'd1 : 8'd12;
      if ($urandom_range(0, 15) != 0 && hi > 8'd12) hi = 8'd12;
      case (kind)
         0: begin
            repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
         end
         1: begin
            offer_byte(cfr_pkg::START_BYTE);
            case ($urandom_range(0, 2))
               0:       len = 8'($urandom_range(0, 1));
               1:       len = tracker.limit;
               default: len = 8'($urandom_range(tracker.limit, 255));
            endcase
            offer_byte(len);
         end
         2: begin
            // truncated frame: the bytes that follow land inside its payload or checksum
            len = 8'($urandom_range(2, hi));
            offer_byte(cfr_pkg::START_BYTE);
            offer_byte(len);
            repeat ($urandom_range(0, len - 1)) offer_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            send_frame(8'($urandom_range(2, hi)), $urandom_range(0, 3) == 0);
         end
      endcase
   endtask

   task automatic run_until(input int unsigned target);
      while (items_sent < target) send_random_frame();
   endtask

   task automatic write_length_limit(input logic [7:0] value);
      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.length_limit <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      tracker.limit = value;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: hunt noise, short lengths, length 0xFF, length at limit
      offer_byte(8'h00);
      offer_byte(8'h7E);
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(8'h00);
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(8'h01);
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(8'hFF);
      offer_byte(8'h02);
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(cfr_pkg::LIMIT_RESET);
      send_frame(8'd2, 1'b0);
      // 0xFF inside the payload, bad then good checksum
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(8'h03);
      offer_byte(8'hFF);
      offer_byte(8'h00);
      offer_byte(8'hFE);
      offer_byte(cfr_pkg::START_BYTE);
      offer_byte(8'h03);
      offer_byte(8'h00);
      offer_byte(8'hFF);
      offer_byte(8'hFD);

      run_until(200);
      // long receiver hold-off while the sender keeps offering
      gaps_on <= 1'b0;
      hold_request <= 1'b1;
      run_until(330);
      gaps_on <= 1'b1;
      run_until(420);

      write_length_limit(8'd255);
      send_frame(8'd254, 1'b0);
      run_until(760);

      write_length_limit(8'd2);
      run_until(800);

      write_length_limit(8'd3);
      run_until(880);

      write_length_limit(8'($urandom_range(4, 64)));
      run_until(980);
      gaps_on <= 1'b0;
      run_until(1100);

      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("PASS checksum_frame_receiver_top");
      end else begin
         $display("FAIL checksum_frame_receiver_top");
      end
      $finish;
   end

endmodule

// ----- checksum_frame_receiver_top.f -----
src/cfr_pkg.sv
src/cfr_if.sv
src/cfr_input_reg.sv
src/cfr_deframer.sv
src/cfr_result_reg.sv
src/checksum_frame_receiver_top.sv
bench/testbench.sv
